// ===== sv/llp_pkg.sv =====
// Types and constants shared by the LL(1) parser modules.
// No dependencies.
package llp_pkg;

  localparam logic [1:0] OP_SYM   = 2'd0;
  localparam logic [1:0] OP_LEN   = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_TOKEN = 2'd3;

  localparam logic [1:0] ACT_MATCH  = 2'd0;
  localparam logic [1:0] ACT_EXPAND = 2'd1;
  localparam logic [1:0] ACT_ACCEPT = 2'd2;
  localparam logic [1:0] ACT_ERROR  = 2'd3;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_MISMATCH = 2'd1;
  localparam logic [1:0] CAUSE_EMPTY    = 2'd2;
  localparam logic [1:0] CAUSE_LIMIT    = 2'd3;

  localparam logic [3:0] END_COL_RESET = 4'd15;

  typedef enum logic [1:0] {ST_IDLE, ST_EXAM, ST_LOOK, ST_PUSH} ctrl_state_t;
  typedef enum logic [1:0] {PS_IDLE, PS_PARSING, PS_DONE} pstat_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] row_nonterminal;
    logic [3:0] column_terminal;
    logic [2:0] slot;
    logic       symbol_is_nonterminal;
    logic [3:0] symbol_index;
    logic [3:0] rhs_length;
    logic       entry_valid;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] expanded_nonterminal;
    logic [3:0] lookahead;
    logic [1:0] error_cause;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       tok_start;
    logic       pop;
    logic       expand;
    logic       push;
    logic       set_done;
    logic       emit;
    logic [1:0] act;
    logic [1:0] cause;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic top_bottom;
    logic top_nt;
    logic top_match;
    logic end_match;
    logic xlimit;
    logic oob;
    logic ent_ok;
    logic overflow;
    logic len_zero;
    logic push_last;
    logic parsing;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/llp_chan_if.sv =====
// Valid/ready channel carrying one payload of type T per beat.
// No dependencies.
interface llp_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/llp_ctrl.sv =====
// Parser sequencer: walks examine / lookup / push steps per token.
// Depends on llp_pkg.
module llp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_opcode,
  output logic          in_ready,
  input  llp_pkg::stat_t stat,
  output llp_pkg::cmd_t  cmd
);
  import llp_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic take;

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take && in_opcode == OP_TOKEN && stat.parsing) state_nxt = ST_EXAM;
      end
      ST_EXAM: begin
        if (stat.out_free) begin
          if (stat.top_bottom || !stat.top_nt || stat.xlimit || stat.oob) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (stat.out_free) begin
          if (!stat.ent_ok || stat.overflow) state_nxt = ST_IDLE;
          else if (stat.len_zero) state_nxt = ST_EXAM;
          else state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (stat.push_last) state_nxt = ST_EXAM;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.tok_start = take && in_opcode == OP_TOKEN;
      end
      ST_EXAM: begin
        if (stat.out_free) begin
          cmd.last = 1'b1;
          if (stat.top_bottom) begin
            cmd.emit = 1'b1;
            cmd.set_done = 1'b1;
            cmd.act = stat.end_match ? ACT_ACCEPT : ACT_ERROR;
            cmd.cause = stat.end_match ? CAUSE_NONE : CAUSE_MISMATCH;
          end else if (!stat.top_nt) begin
            cmd.emit = 1'b1;
            cmd.pop = stat.top_match;
            cmd.set_done = !stat.top_match;
            cmd.act = stat.top_match ? ACT_MATCH : ACT_ERROR;
            cmd.cause = stat.top_match ? CAUSE_NONE : CAUSE_MISMATCH;
          end else if (stat.xlimit) begin
            cmd.emit = 1'b1;
            cmd.set_done = 1'b1;
            cmd.act = ACT_ERROR;
            cmd.cause = CAUSE_LIMIT;
          end else if (stat.oob) begin
            cmd.emit = 1'b1;
            cmd.set_done = 1'b1;
            cmd.act = ACT_ERROR;
            cmd.cause = CAUSE_EMPTY;
          end
        end
      end
      ST_LOOK: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!stat.ent_ok || stat.overflow) begin
            cmd.set_done = 1'b1;
            cmd.last = 1'b1;
            cmd.act = ACT_ERROR;
            cmd.cause = stat.ent_ok ? CAUSE_LIMIT : CAUSE_EMPTY;
          end else begin
            cmd.expand = 1'b1;
            cmd.act = ACT_EXPAND;
            cmd.cause = CAUSE_NONE;
          end
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/llp_datapath.sv =====
// Parser datapath: parse table memories, stack, counters, result register.
// Depends on llp_pkg.
module llp_datapath #(
  parameter int NUM_NONTERMINALS = 16,
  parameter int NUM_TERMINALS = 16,
  parameter int MAX_RHS = 8,
  parameter int STACK_DEPTH = 32,
  parameter int MAX_EXPANSIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_take,
  input  llp_pkg::in_item_t  in_item,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  llp_pkg::cmd_t      cmd,
  output llp_pkg::stat_t     stat,
  output logic               out_valid,
  input  logic               out_ready,
  output llp_pkg::out_item_t out_item
);
  import llp_pkg::*;

  localparam int ENTRIES = NUM_NONTERMINALS * NUM_TERMINALS;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RHS_DEPTH = ENTRIES * MAX_RHS;
  localparam int RAW = $clog2(RHS_DEPTH);
  localparam int LW = $clog2(MAX_RHS + 1);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int XW = $clog2(MAX_EXPANSIONS + 1);

  logic [4:0]         rhs_mem [RHS_DEPTH];
  logic [LW-1:0]      len_mem [ENTRIES];
  logic [ENTRIES-1:0] ok_r;
  logic [5:0]         stk_r [STACK_DEPTH];

  logic [SPW-1:0] sp_r;
  logic [3:0]     col_r;
  logic [3:0]     endc_r;
  logic [XW-1:0]  xcnt_r;
  logic [LW-1:0]  cnt_r;
  logic [EW-1:0]  ent_r;
  pstat_t         ps_r;
  logic [LW-1:0]  len_q;
  logic           ok_q;
  logic [4:0]     rhs_q;
  logic           out_valid_r;
  out_item_t      out_r;

  logic [SPW-1:0] sp_m1;
  logic [5:0]     top;
  logic [EW-1:0]  ent_cur;
  logic [EW-1:0]  ld_ent;
  logic           ld_in_range;
  logic [LW-1:0]  len_sat;
  logic [LW-1:0]  rd_slot;
  logic [EW-1:0]  rd_ent;
  logic [RAW-1:0] rd_addr;
  logic [RAW-1:0] wr_addr;

  assign sp_m1 = sp_r - SPW'(1);
  assign top = stk_r[sp_m1[SIW-1:0]];
  assign ent_cur = EW'(32'(top[3:0]) * NUM_TERMINALS + 32'(col_r));
  assign ld_ent = EW'(32'(in_item.row_nonterminal) * NUM_TERMINALS
                      + 32'(in_item.column_terminal));
  assign ld_in_range = (32'(in_item.row_nonterminal) < NUM_NONTERMINALS)
                    && (32'(in_item.column_terminal) < NUM_TERMINALS);
  assign len_sat = (32'(in_item.rhs_length) > MAX_RHS) ? LW'(MAX_RHS)
                                                       : LW'(in_item.rhs_length);
  // Symbols are pushed from the last slot down.
  assign rd_slot = cmd.expand ? (len_q - LW'(1)) : (cnt_r - LW'(2));
  assign rd_ent = cmd.expand ? ent_cur : ent_r;
  assign rd_addr = RAW'(32'(rd_ent) * MAX_RHS + 32'(rd_slot));
  assign wr_addr = RAW'(32'(ld_ent) * MAX_RHS + 32'(in_item.slot));

  always_comb begin
    stat.top_bottom = top[5];
    stat.top_nt = top[4];
    stat.top_match = top[3:0] == col_r;
    stat.end_match = col_r == endc_r;
    stat.xlimit = 32'(xcnt_r) >= MAX_EXPANSIONS;
    stat.oob = (32'(top[3:0]) >= NUM_NONTERMINALS) || (32'(col_r) >= NUM_TERMINALS);
    stat.ent_ok = ok_q;
    stat.overflow = (32'(sp_m1) + 32'(len_q)) > STACK_DEPTH;
    stat.len_zero = len_q == '0;
    stat.push_last = cnt_r == LW'(1);
    stat.parsing = ps_r == PS_PARSING;
    stat.out_free = !out_valid_r || out_ready;
  end

  // Table memories and registered reads.
  always_ff @(posedge clk) begin
    if (in_take && in_item.opcode == OP_SYM && ld_in_range && 32'(in_item.slot) < MAX_RHS) begin
      rhs_mem[wr_addr] <= {in_item.symbol_is_nonterminal, in_item.symbol_index};
    end
    if (in_take && in_item.opcode == OP_LEN && ld_in_range) begin
      len_mem[ld_ent] <= len_sat;
    end
    rhs_q <= rhs_mem[rd_addr];
    len_q <= len_mem[ent_cur];
    ok_q <= ok_r[ent_cur];
  end

  // Stack contents and per-token working registers.
  always_ff @(posedge clk) begin
    if (in_take && in_item.opcode == OP_START) begin
      stk_r[0] <= 6'h20;
      stk_r[1] <= {2'b01, in_item.row_nonterminal};
    end
    if (cmd.push) begin
      stk_r[sp_r[SIW-1:0]] <= {1'b0, rhs_q};
    end
    if (cmd.tok_start) begin
      col_r <= in_item.column_terminal;
    end
    if (cmd.expand) begin
      cnt_r <= len_q;
      ent_r <= ent_cur;
    end else if (cmd.push) begin
      cnt_r <= cnt_r - LW'(1);
    end
    if (cmd.emit) begin
      out_r.action <= cmd.act;
      out_r.expanded_nonterminal <= (cmd.act == ACT_EXPAND) ? top[3:0] : 4'd0;
      out_r.lookahead <= col_r;
      out_r.error_cause <= cmd.cause;
      out_r.last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= '0;
      sp_r <= '0;
      ps_r <= PS_IDLE;
      xcnt_r <= '0;
      endc_r <= END_COL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) endc_r <= cfg_data;
      if (in_take && in_item.opcode == OP_LEN && ld_in_range) begin
        ok_r[ld_ent] <= in_item.entry_valid;
      end
      if (in_take && in_item.opcode == OP_START) begin
        sp_r <= SPW'(2);
        ps_r <= PS_PARSING;
      end else if (cmd.pop || cmd.expand) begin
        sp_r <= sp_m1;
      end else if (cmd.push) begin
        sp_r <= sp_r + SPW'(1);
      end
      if (cmd.set_done) ps_r <= PS_DONE;
      if (cmd.tok_start) xcnt_r <= '0;
      else if (cmd.expand) xcnt_r <= xcnt_r + XW'(1);
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule

// ===== sv/ll1_predictive_parser.sv =====
// LL(1) predictive parser. Table loads and start items are taken while idle.
// A token is taken while idle and then the final stack top is examined, plus
// per expansion an examine step, a lookup step and a push step per symbol
// (one table memory read port); each result beat appears in the cycle after its step.
// Examine and lookup steps stall while a result beat waits; no new item is taken mid-token.
// Reset (synchronous, rst_n low) empties the stack, marks all table entries
// empty, idles the parser and sets end_column to 15; symbols stay unwritten.
module ll1_predictive_parser #(
  parameter int NUM_NONTERMINALS = 16,
  parameter int NUM_TERMINALS = 16,
  parameter int MAX_RHS = 8,
  parameter int STACK_DEPTH = 32,
  parameter int MAX_EXPANSIONS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  llp_chan_if.sink   in_chan,
  llp_chan_if.source out_chan,
  llp_chan_if.sink   cfg_chan
);
  import llp_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_rdy;
  logic  in_take;

  assign in_chan.ready = in_rdy;
  assign in_take = in_chan.valid && in_rdy;
  assign cfg_chan.ready = 1'b1;

  llp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.data.opcode),
    .in_ready  (in_rdy),
    .stat      (stat),
    .cmd       (cmd)
  );

  llp_datapath #(
    .NUM_NONTERMINALS (NUM_NONTERMINALS),
    .NUM_TERMINALS    (NUM_TERMINALS),
    .MAX_RHS          (MAX_RHS),
    .STACK_DEPTH      (STACK_DEPTH),
    .MAX_EXPANSIONS   (MAX_EXPANSIONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_item   (in_chan.data),
    .cfg_we    (cfg_chan.valid),
    .cfg_data  (cfg_chan.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (out_chan.data)
  );

endmodule

// ===== sv/llp_checker.sv =====
// Port-level checks for the LL(1) parser result channel.
// Depends on llp_pkg; bound to ll1_predictive_parser.
module llp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_action,
  input logic [1:0] out_cause,
  input logic       out_last
);
  import llp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_expand_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_action == ACT_EXPAND) != out_last))
    else $error("last flag disagrees with action");

  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_action == ACT_ERROR) == (out_cause != CAUSE_NONE)))
    else $error("error cause disagrees with action");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while a token is still in progress");

endmodule

bind ll1_predictive_parser llp_checker u_llp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_action (out_chan.data.action),
  .out_cause  (out_chan.data.error_cause),
  .out_last   (out_chan.data.last)
);

// ===== bench/ll1_predictive_parser_tb.sv =====
// Self-checking bench for ll1_predictive_parser: table loads, parse runs, end column changes.
// Depends on llp_pkg and llp_chan_if; a built-in parser model predicts every result beat.
`timescale 1ns / 100ps

module ll1_predictive_parser_tb;
  import llp_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS = 460;

  typedef struct {
    logic [255:0][7:0][4:0] sym;
    logic [255:0][4:0]      info;
    logic [31:0][5:0]       stk;
    int                     sp;
    pstat_t                 st;
    logic [3:0]             endc;
  } parser_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  llp_chan_if #(.T(in_item_t))   in_if ();
  llp_chan_if #(.T(out_item_t))  out_if ();
  llp_chan_if #(.T(logic [3:0])) cfg_if ();

  ll1_predictive_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source),
    .cfg_chan (cfg_if.sink)
  );

  always #2 clk = ~clk;

  in_item_t   pend_items[$];
  out_item_t  expected_beats[$];
  parser_t    chk_model;
  parser_t    gen_model;
  logic [7:0] slot_written [256];
  int         cyc = 0;
  int         stall_cnt = 0;
  int         sent_cnt = 0;
  bit         failed = 0;
  logic       in_fired = 1'b0;

  function automatic void model_reset(inout parser_t m);
    m.sym  = '0;
    m.info = '0;
    m.stk  = '0;
    m.sp   = 0;
    m.st   = PS_IDLE;
    m.endc = END_COL_RESET;
  endfunction

  function automatic out_item_t beat(logic [1:0] act, logic [3:0] nt, logic [3:0] look,
                                     logic [1:0] cause, logic lst);
    out_item_t r;
    r.action = act;
    r.expanded_nonterminal = nt;
    r.lookahead = look;
    r.error_cause = cause;
    r.last = lst;
    return r;
  endfunction

  // Advance the parser model by one input item; rs gets the result beats.
  function automatic void parse_step(inout parser_t m, input in_item_t it,
                                     output out_item_t rs[$]);
    logic [5:0] top;
    logic [7:0] e;
    logic [3:0] col;
    int         len;
    int         nexp;
    rs = {};
    col = it.column_terminal;
    e = {it.row_nonterminal, it.column_terminal};
    case (it.opcode)
      OP_SYM: begin
        m.sym[e][it.slot] = {it.symbol_is_nonterminal, it.symbol_index};
      end
      OP_LEN: begin
        len = (it.rhs_length > 8) ? 8 : int'(it.rhs_length);
        m.info[e] = {it.entry_valid, 4'(len)};
      end
      OP_START: begin
        m.stk[0] = 6'h20;
        m.stk[1] = {2'b01, it.row_nonterminal};
        m.sp = 2;
        m.st = PS_PARSING;
      end
      default: begin
        if (m.st != PS_PARSING || m.sp == 0 || m.sp > 32) return;
        nexp = 0;
        forever begin
          top = m.stk[m.sp-1];
          if (top[5]) begin
            m.st = PS_DONE;
            if (col == m.endc) rs.push_back(beat(ACT_ACCEPT, 0, col, CAUSE_NONE, 1));
            else rs.push_back(beat(ACT_ERROR, 0, col, CAUSE_MISMATCH, 1));
            return;
          end
          if (!top[4]) begin
            if (top[3:0] == col) begin
              m.sp--;
              rs.push_back(beat(ACT_MATCH, 0, col, CAUSE_NONE, 1));
            end else begin
              m.st = PS_DONE;
              rs.push_back(beat(ACT_ERROR, 0, col, CAUSE_MISMATCH, 1));
            end
            return;
          end
          e = {top[3:0], col};
          if (nexp >= 16) begin
            m.st = PS_DONE;
            rs.push_back(beat(ACT_ERROR, 0, col, CAUSE_LIMIT, 1));
            return;
          end
          if (!m.info[e][4]) begin
            m.st = PS_DONE;
            rs.push_back(beat(ACT_ERROR, 0, col, CAUSE_EMPTY, 1));
            return;
          end
          len = int'(m.info[e][3:0]);
          if (m.sp - 1 + len > 32) begin
            m.st = PS_DONE;
            rs.push_back(beat(ACT_ERROR, 0, col, CAUSE_LIMIT, 1));
            return;
          end
          rs.push_back(beat(ACT_EXPAND, top[3:0], col, CAUSE_NONE, 0));
          m.sp--;
          for (int i = len; i > 0; i--) begin
            m.stk[m.sp] = {1'b0, m.sym[e][i-1]};
            m.sp++;
          end
          nexp++;
        end
      end
    endcase
  endfunction

  function automatic in_item_t mk(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                                  logic [2:0] slot, logic snt, logic [3:0] sidx,
                                  logic [3:0] len, logic vld);
    in_item_t it;
    it.opcode = op;
    it.row_nonterminal = row;
    it.column_terminal = col;
    it.slot = slot;
    it.symbol_is_nonterminal = snt;
    it.symbol_index = sidx;
    it.rhs_length = len;
    it.entry_valid = vld;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    out_item_t d[$];
    if (it.opcode == OP_SYM) slot_written[{it.row_nonterminal, it.column_terminal}][it.slot] = 1'b1;
    pend_items.push_back(it);
    parse_step(gen_model, it, d);
    sent_cnt++;
  endtask

  task automatic load_entry(input logic [3:0] row, input logic [3:0] col, input int len,
                            input bit vld, input int nrows, input int ncols);
    bit snt;
    if (vld) begin
      for (int s = 0; s < len && s < 8; s++) begin
        snt = ($urandom_range(99) < 40);
        send(mk(OP_SYM, row, col, 3'(s), snt,
                4'(snt ? $urandom_range(nrows-1) : $urandom_range(ncols-1)), 0, 0));
      end
    end
    send(mk(OP_LEN, row, col, 0, 0, 0, 4'(len), vld));
  endtask

  // Random fields; fill any unwritten slot a valid length would expose.
  task automatic send_noise();
    in_item_t it;
    int       len;
    it = in_item_t'($urandom);
    if (it.opcode == OP_LEN && it.entry_valid) begin
      len = (it.rhs_length > 8) ? 8 : int'(it.rhs_length);
      for (int s = 0; s < len; s++)
        if (!slot_written[{it.row_nonterminal, it.column_terminal}][s])
          send(mk(OP_SYM, it.row_nonterminal, it.column_terminal, 3'(s),
                  1'($urandom), 4'($urandom), 0, 0));
    end
    send(it);
  endtask

  // Prefer a token that the current parse will match or accept.
  function automatic logic [3:0] pick_token();
    parser_t    t;
    out_item_t  r[$];
    logic [3:0] ok[$];
    for (int c = 0; c < 16; c++) begin
      t = gen_model;
      parse_step(t, mk(OP_TOKEN, 0, 4'(c), 0, 0, 0, 0, 0), r);
      if (r.size() > 0 && r[r.size()-1].action inside {ACT_MATCH, ACT_ACCEPT}) ok.push_back(4'(c));
    end
    if (ok.size() > 0 && $urandom_range(99) < 85) return ok[$urandom_range(ok.size()-1)];
    return 4'($urandom_range(15));
  endfunction

  task automatic drain();
    while (pend_items.size() > 0 || in_if.valid || expected_beats.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_end_column(input logic [3:0] v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    gen_model.endc = v;
  endtask

  // Driver: new beat when the channel is empty or the last one was taken.
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_fired)) begin
      if (pend_items.size() > 0 && (cyc inside {[1000:2000]} || $urandom_range(99) >= 26)) begin
        in_if.data <= pend_items.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    if (rst_n) out_if.ready <= (cyc inside {[1000:2000]} || $urandom_range(99) >= 26);
  end

  // Monitor: predict on accepted items, check result beats, watch for hangs.
  always @(posedge clk) begin
    out_item_t rs[$];
    out_item_t exp_b;
    out_item_t got;
    bit        any;
    cyc <= cyc + 1;
    in_fired <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      any = 0;
      if (cfg_if.valid && cfg_if.ready) begin
        chk_model.endc = cfg_if.data;
        any = 1;
      end
      if (in_if.valid && in_if.ready) begin
        parse_step(chk_model, in_if.data, rs);
        foreach (rs[i]) expected_beats.push_back(rs[i]);
        any = 1;
      end
      if (out_if.valid && out_if.ready) begin
        any = 1;
        got = out_if.data;
        if (expected_beats.size() == 0) begin
          failed = 1;
          $display("%0t: unexpected result beat %p", $time, got);
        end else begin
          exp_b = expected_beats.pop_front();
          if (got.action !== exp_b.action || got.expanded_nonterminal !== exp_b.expanded_nonterminal
              || got.lookahead !== exp_b.lookahead || got.error_cause !== exp_b.error_cause
              || got.last !== exp_b.last) begin
            failed = 1;
            $display("%0t: mismatch expected %p actual %p", $time, exp_b, got);
          end
        end
      end
      stall_cnt <= any ? 0 : stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int nrows;
    int ncols;
    int phase_start;
    int ntok;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    model_reset(chk_model);
    model_reset(gen_model);
    foreach (slot_written[i]) slot_written[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: token while idle, saturated all-ones entry overflowing the
    // stack, self-recursive entry hitting the expansion limit, epsilon then accept.
    send(mk(OP_TOKEN, 0, 4'd3, 0, 0, 0, 0, 0));
    for (int s = 0; s < 8; s++) send(mk(OP_SYM, 4'd15, 4'd15, 3'(s), 1, 4'd15, 0, 0));
    send(mk(OP_LEN, 4'd15, 4'd15, 0, 0, 0, 4'd15, 1));
    send(mk(OP_START, 4'd15, 0, 0, 0, 0, 0, 0));
    send(mk(OP_TOKEN, 0, 4'd15, 0, 0, 0, 0, 0));
    send(mk(OP_SYM, 4'd13, 4'd0, 0, 1, 4'd13, 0, 0));
    send(mk(OP_LEN, 4'd13, 4'd0, 0, 0, 0, 4'd1, 1));
    send(mk(OP_START, 4'd13, 0, 0, 0, 0, 0, 0));
    send(mk(OP_TOKEN, 0, 4'd0, 0, 0, 0, 0, 0));
    send(mk(OP_TOKEN, 0, 4'd0, 0, 0, 0, 0, 0));
    send(mk(OP_LEN, 4'd1, 4'd15, 0, 0, 0, 4'd0, 1));
    send(mk(OP_START, 4'd1, 0, 0, 0, 0, 0, 0));
    send(mk(OP_TOKEN, 0, 4'd15, 0, 0, 0, 0, 0));

    sent_cnt = 0;
    for (int ph = 0; sent_cnt < RANDOM_ITEMS; ph++) begin
      if (ph > 0) begin
        drain();
        write_end_column((ph % 3 == 1) ? 4'd0 : (ph % 3 == 2) ? 4'($urandom) : 4'd15);
      end
      nrows = $urandom_range(2, 4);
      ncols = $urandom_range(2, 4);
      phase_start = sent_cnt;
      for (int r = 0; r < nrows; r++)
        for (int c = 0; c <= ncols; c++)
          load_entry(4'(r), (c == ncols) ? gen_model.endc : 4'(c),
                     ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 3),
                     $urandom_range(99) < 70, nrows, ncols);
      while (sent_cnt - phase_start < 90) begin
        send(mk(OP_START, 4'($urandom_range(nrows-1)), 4'($urandom), 3'($urandom),
                1'($urandom), 4'($urandom), 4'($urandom), 1'($urandom)));
        ntok = 0;
        while (gen_model.st == PS_PARSING && ntok < 12) begin
          if ($urandom_range(99) < 6) send_noise();
          else send(mk(OP_TOKEN, 4'($urandom), pick_token(), 3'($urandom), 1'($urandom),
                       4'($urandom), 4'($urandom), 1'($urandom)));
          ntok++;
        end
        if ($urandom_range(99) < 20) send(mk(OP_TOKEN, 0, 4'($urandom), 0, 0, 0, 0, 0));
      end
    end
    drain();
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/llp_pkg.sv
sv/llp_chan_if.sv
sv/llp_ctrl.sv
sv/llp_datapath.sv
sv/ll1_predictive_parser.sv
sv/llp_checker.sv
bench/ll1_predictive_parser_tb.sv
